>>> sv/rcfc_pkg.sv
// Shared types and constants for the remote-control frame checker.
package rcfc_pkg;

    localparam int unsigned FRAME_BYTES = 25;
    localparam int unsigned COUNT_W     = 5;
    localparam int unsigned NUM_FLOATS  = 4;
    localparam int unsigned NUM_MODES   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 5'd31;
    localparam logic [COUNT_W-1:0] ADDR_END    = 5'd3;
    localparam logic [COUNT_W-1:0] FLOAT_START = 5'd3;
    localparam logic [COUNT_W-1:0] MODE_START  = 5'd19;
    localparam logic [COUNT_W-1:0] MODE_END    = 5'd24;
    localparam logic [COUNT_W-1:0] SUM_END     = 5'(FRAME_BYTES - 1);

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_BAD_LENGTH = 3'd1,
        STATUS_BAD_TARGET = 3'd2,
        STATUS_CHECKSUM   = 3'd3,
        STATUS_BAD_FLOAT  = 3'd4,
        STATUS_BAD_MODE   = 3'd5
    } status_code_t;

    typedef struct packed {
        status_code_t status;
        logic [31:0]  rudder;
        logic [31:0]  throttle;
        logic [31:0]  aileron;
        logic [31:0]  elevator;
        logic [7:0]   arm;
        logic [7:0]   flip;
        logic [7:0]   control;
        logic [7:0]   altitude;
        logic [7:0]   attitude;
    } rcfc_result_t;

    function automatic logic exponent_all_ones(input logic [31:0] bits);
        return &bits[30:23];
    endfunction

endpackage

>>> sv/rcfc_input_stage.sv
// Input register for received bytes, with hand-off to the frame logic.
module rcfc_input_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] frame_byte,
    input  logic       frame_end,
    input  logic       out_free,
    output logic       step,
    output logic [7:0] step_byte,
    output logic       step_end
);
    import rcfc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;
    logic       accept;

    // A byte that closes a frame needs room in the output register.
    assign step      = valid_reg && (!end_reg || out_free);
    assign in_stall  = valid_reg && !step;
    assign accept    = in_valid && !in_stall;
    assign step_byte = byte_reg;
    assign step_end  = end_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= frame_byte;
            end_reg  <= frame_end;
        end
    end

endmodule

>>> sv/rcfc_frame_state.sv
// Per-frame counters, field capture and the end-of-frame checks.
module rcfc_frame_state (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [23:0]           cfg_data,
    input  logic                  step,
    input  logic [7:0]            step_byte,
    input  logic                  step_end,
    output logic                  res_valid,
    output rcfc_pkg::rcfc_result_t res
);
    import rcfc_pkg::*;

    logic [23:0]        target_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [7:0]         sum_reg;
    logic [7:0]         sum_next;
    logic               match_reg;
    logic               match_next;
    logic [31:0]        float_reg [NUM_FLOATS];
    logic [31:0]        float_next [NUM_FLOATS];
    logic [7:0]         mode_reg [NUM_MODES];
    logic [7:0]         mode_next [NUM_MODES];
    logic [COUNT_W-1:0] rel;
    logic [COUNT_W-1:0] mode_idx;
    logic [7:0]         want;
    logic               exp_saturated;
    status_code_t       status;

    assign rel       = count_reg - FLOAT_START;
    assign mode_idx  = count_reg - MODE_START;
    assign res_valid = step && step_end;

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    want = target_reg[7:0];
            2'd1:    want = target_reg[15:8];
            default: want = target_reg[23:16];
        endcase
    end

    always_comb
    begin
        exp_saturated = 1'b0;
        for (int k = 0; k < NUM_FLOATS; k++)
        begin
            exp_saturated = exp_saturated | exponent_all_ones(float_reg[k]);
        end
    end

    // A closing byte is only ever the checksum when the length is right,
    // so the checks read the state left by the earlier bytes.
    always_comb
    begin
        if (count_reg != SUM_END)
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (!match_reg)
        begin
            status = STATUS_BAD_TARGET;
        end
        else if (sum_reg != step_byte)
        begin
            status = STATUS_CHECKSUM;
        end
        else if (exp_saturated)
        begin
            status = STATUS_BAD_FLOAT;
        end
        else if (!(mode_reg[2] inside {8'd0, 8'd1}) || !(mode_reg[3] inside {8'd4, 8'd5}))
        begin
            status = STATUS_BAD_MODE;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    always_comb
    begin
        res = '0;
        res.status = status;
        if (status == STATUS_OK)
        begin
            res.rudder   = float_reg[0];
            res.throttle = float_reg[1];
            res.aileron  = float_reg[2];
            res.elevator = float_reg[3];
            res.arm      = mode_reg[0];
            res.flip     = mode_reg[1];
            res.control  = mode_reg[2];
            res.altitude = mode_reg[3];
            res.attitude = mode_reg[4];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        match_next = match_reg;
        float_next = float_reg;
        mode_next  = mode_reg;
        if (step)
        begin
            if (step_end)
            begin
                count_next = '0;
                sum_next   = '0;
                match_next = 1'b1;
                for (int k = 0; k < NUM_FLOATS; k++)
                begin
                    float_next[k] = '0;
                end
                for (int k = 0; k < NUM_MODES; k++)
                begin
                    mode_next[k] = '0;
                end
            end
            else
            begin
                if (count_reg < ADDR_END && step_byte != want)
                begin
                    match_next = 1'b0;
                end
                if (count_reg >= FLOAT_START && count_reg < MODE_START)
                begin
                    case (rel[1:0])
                        2'd0:    float_next[rel[3:2]][7:0]   = step_byte;
                        2'd1:    float_next[rel[3:2]][15:8]  = step_byte;
                        2'd2:    float_next[rel[3:2]][23:16] = step_byte;
                        default: float_next[rel[3:2]][31:24] = step_byte;
                    endcase
                end
                if (count_reg >= MODE_START && count_reg < MODE_END)
                begin
                    mode_next[mode_idx[2:0]] = step_byte;
                end
                if (count_reg < SUM_END)
                begin
                    sum_next = sum_reg + step_byte;
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            match_reg  <= 1'b1;
            for (int k = 0; k < NUM_FLOATS; k++)
            begin
                float_reg[k] <= '0;
            end
            for (int k = 0; k < NUM_MODES; k++)
            begin
                mode_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                target_reg <= cfg_data;
            end
            count_reg <= count_next;
            sum_reg   <= sum_next;
            match_reg <= match_next;
            float_reg <= float_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

>>> sv/rcfc_output_stage.sv
// Result register towards the downstream consumer.
module rcfc_output_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   res_valid,
    input  rcfc_pkg::rcfc_result_t res,
    output logic                   out_free,
    output logic                   out_valid,
    input  logic                   out_stall,
    output rcfc_pkg::rcfc_result_t out_res
);
    import rcfc_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    rcfc_result_t res_reg;

    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> sv/rc_control_frame_checker_core.sv
// Top level of the remote-control frame checker.
// The checker takes one frame byte per request on the input channel, with
// frame_end set on the last byte, and sustains one byte per clock cycle. A
// byte passes through an input register and then updates the frame state
// (byte count, running sum, target match and captured fields) in the next
// cycle unless it is a closing byte that is held up; a closing byte produces
// one result request, which is written into the result register and
// presented on the output channel from there. All other bytes produce no
// result. The result register and the input register together let a new
// byte be taken while a finished result still waits downstream; only a
// closing byte that finds the result register full and stalled holds up
// the input.
// The status code is 0 for a good frame, 1 for a wrong length, 2 for a
// target address mismatch, 3 for a checksum error, 4 for a non-finite
// control value and 5 for an invalid mode; on any non-zero code all other
// result fields read as zero. The target address is written through the
// configuration channel, which is always ready, and should be changed only
// while no frame is in progress.
module rc_control_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [23:0] target_address,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status_code,
    output logic [31:0] rudder_bits,
    output logic [31:0] throttle_bits,
    output logic [31:0] aileron_bits,
    output logic [31:0] elevator_bits,
    output logic [7:0]  arm_button,
    output logic [7:0]  flip_button,
    output logic [7:0]  ctrl_mode,
    output logic [7:0]  altitude_mode,
    output logic [7:0]  attitude_reset
);
    import rcfc_pkg::*;

    logic         out_free;
    logic         step;
    logic [7:0]   step_byte;
    logic         step_end;
    logic         res_valid;
    rcfc_result_t res;
    rcfc_result_t out_res;

    // The single register can always be written.
    assign cfg_ready = 1'b1;

    rcfc_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .out_free   (out_free),
        .step       (step),
        .step_byte  (step_byte),
        .step_end   (step_end)
    );

    rcfc_frame_state u_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (target_address),
        .step      (step),
        .step_byte (step_byte),
        .step_end  (step_end),
        .res_valid (res_valid),
        .res       (res)
    );

    rcfc_output_stage u_output (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign status_code    = out_res.status;
    assign rudder_bits    = out_res.rudder;
    assign throttle_bits  = out_res.throttle;
    assign aileron_bits   = out_res.aileron;
    assign elevator_bits  = out_res.elevator;
    assign arm_button     = out_res.arm;
    assign flip_button    = out_res.flip;
    assign ctrl_mode      = out_res.control;
    assign altitude_mode  = out_res.altitude;
    assign attitude_reset = out_res.attitude;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the remote-control frame checker core.
module tb_top;
    import rcfc_pkg::*;

    // One request on the input channel: a frame byte and its closing flag.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_req_t;

    // Shapes of frame that the stimulus can build. Most are well formed, so
    // that the deeper checks (checksum, float exponents, modes) are reached.
    typedef enum int {
        FK_GOOD,
        FK_EXTREME,
        FK_SHORT,
        FK_LONG,
        FK_TARGET,
        FK_CHECKSUM,
        FK_BAD_FLOAT,
        FK_BAD_MODE,
        FK_NOISE
    } frame_kind_t;

    localparam int NUM_PHASES  = 6;
    localparam int PHASE_BYTES = 255;
    localparam int SHOW_LIMIT  = 10;

    // Every input of the checker starts at a known value.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] target_address = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  frame_byte = '0;
    logic        frame_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status_code;
    logic [31:0] rudder_bits;
    logic [31:0] throttle_bits;
    logic [31:0] aileron_bits;
    logic [31:0] elevator_bits;
    logic [7:0]  arm_button;
    logic [7:0]  flip_button;
    logic [7:0]  ctrl_mode;
    logic [7:0]  altitude_mode;
    logic [7:0]  attitude_reset;

    rc_control_frame_checker_core u_dut (.*);

    // Bytes waiting to be offered, and verdicts waiting to come out.
    frame_req_t   byte_q [$];
    rcfc_result_t verdict_q [$];

    // Our own view of the checker: the target address last written and the
    // state of the frame in progress.
    logic [23:0] model_target = '0;
    logic [4:0]  rx_count;
    logic [7:0]  rx_sum;
    logic        rx_target_ok;
    logic [31:0] rx_float [4];
    logic [7:0]  rx_mode [5];

    bit quiet_phase = 1'b0;
    int gap_left = 0;
    int hold_left = 0;
    int fault_count = 0;
    int bytes_sent = 0;
    int frames_queued = 0;
    int verdicts_checked = 0;
    int target_writes = 0;
    int status_tally [6];

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Returns every frame register to its state after a closing byte.
    function automatic void restart_frame();
        rx_count = '0;
        rx_sum = '0;
        rx_target_ok = 1'b1;
        foreach (rx_float[i])
            rx_float[i] = '0;
        foreach (rx_mode[i])
            rx_mode[i] = '0;
    endfunction

    // Folds one accepted byte into the frame state. A closing byte yields the
    // verdict the checker must produce, which is queued for the monitor.
    function automatic void track_frame_byte(logic [7:0] value, logic last);
        logic [4:0]   pos;
        logic [4:0]   frame_len;
        int           word;
        int           lane;
        rcfc_result_t verdict;
        pos = rx_count;
        // The leading three bytes must match the target, low byte first.
        if (pos < ADDR_END && value != model_target[8*pos +: 8])
            rx_target_ok = 1'b0;
        // Bytes 3 to 18 fill the four floats, each one little-endian.
        if (pos >= FLOAT_START && pos < MODE_START)
        begin
            word = int'(pos - FLOAT_START) / 4;
            lane = int'(pos - FLOAT_START) % 4;
            rx_float[word][8*lane +: 8] = value;
        end
        if (pos >= MODE_START && pos < MODE_END)
            rx_mode[pos - MODE_START] = value;
        // The count sticks at its top value on an overlong frame.
        frame_len = (pos == COUNT_MAX) ? COUNT_MAX : pos + 5'd1;
        if (!last)
        begin
            if (pos < SUM_END)
                rx_sum = rx_sum + value;
            rx_count = frame_len;
            return;
        end
        verdict = '0;
        if (frame_len != 5'(FRAME_BYTES))
            verdict.status = STATUS_BAD_LENGTH;
        else if (!rx_target_ok)
            verdict.status = STATUS_BAD_TARGET;
        else if (rx_sum != value)
            verdict.status = STATUS_CHECKSUM;
        else if ((&rx_float[0][30:23]) || (&rx_float[1][30:23]) ||
                 (&rx_float[2][30:23]) || (&rx_float[3][30:23]))
            verdict.status = STATUS_BAD_FLOAT;
        else if ((rx_mode[2] != 8'd0 && rx_mode[2] != 8'd1) ||
                 (rx_mode[3] != 8'd4 && rx_mode[3] != 8'd5))
            verdict.status = STATUS_BAD_MODE;
        else
            verdict.status = STATUS_OK;
        // Captured fields are only passed on for a good frame.
        if (verdict.status == STATUS_OK)
        begin
            verdict.rudder = rx_float[0];
            verdict.throttle = rx_float[1];
            verdict.aileron = rx_float[2];
            verdict.elevator = rx_float[3];
            verdict.arm = rx_mode[0];
            verdict.flip = rx_mode[1];
            verdict.control = rx_mode[2];
            verdict.altitude = rx_mode[3];
            verdict.attitude = rx_mode[4];
        end
        verdict_q.push_back(verdict);
        restart_frame();
    endfunction

    // Idle lengths: mostly none or short, now and then long, and none at
    // all during a quiet phase so that back-to-back traffic is seen too.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic frame_kind_t pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return FK_GOOD;
        if (roll < 53)
            return FK_SHORT;
        if (roll < 61)
            return FK_LONG;
        if (roll < 69)
            return FK_TARGET;
        if (roll < 77)
            return FK_CHECKSUM;
        if (roll < 85)
            return FK_BAD_FLOAT;
        if (roll < 93)
            return FK_BAD_MODE;
        return FK_NOISE;
    endfunction

    // Builds one frame of the given kind for the current target and queues
    // its bytes. A well-formed frame starts from the target, four finite
    // floats and legal modes, and closes with the byte sum of the first 24.
    task automatic queue_frame(frame_kind_t kind);
        logic [7:0]  body [25];
        logic [31:0] ctl;
        logic [7:0]  sum;
        frame_req_t  req;
        int          k;
        int          n;
        int          bad_float;
        bad_float = $urandom_range(0, 3);
        for (k = 0; k < 3; k++)
            body[k] = model_target[8*k +: 8];
        for (k = 0; k < 4; k++)
        begin
            ctl = $urandom();
            if (ctl[30:23] == 8'hFF)
                ctl[23] = 1'b0;
            if (kind == FK_EXTREME)
            begin
                // Largest finite magnitudes, zero, and the largest subnormal.
                case (k)
                    0: ctl = 32'h7F7FFFFF;
                    1: ctl = 32'hFF7FFFFF;
                    2: ctl = 32'h00000000;
                    default: ctl = 32'h807FFFFF;
                endcase
            end
            // An all-ones exponent is an infinity or a NaN.
            if (kind == FK_BAD_FLOAT && k == bad_float)
                ctl[30:23] = 8'hFF;
            for (n = 0; n < 4; n++)
                body[3 + 4*k + n] = ctl[8*n +: 8];
        end
        body[19] = 8'($urandom_range(0, 255));
        body[20] = 8'($urandom_range(0, 255));
        body[21] = 8'($urandom_range(0, 1));
        body[22] = 8'($urandom_range(4, 5));
        body[23] = 8'($urandom_range(0, 255));
        case (kind)
            FK_EXTREME:
            begin
                body[19] = 8'hFF;
                body[20] = 8'h00;
                body[21] = 8'd1;
                body[22] = 8'd5;
                body[23] = 8'hFF;
            end
            FK_TARGET:
                body[$urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
            FK_BAD_FLOAT:
            begin
                // A bad mode as well must not change the reported error.
                if ($urandom_range(0, 1) != 0)
                    body[21] = 8'hFF;
            end
            FK_BAD_MODE:
            begin
                if ($urandom_range(0, 1) != 0)
                    body[21] = 8'($urandom_range(2, 255));
                else
                begin
                    do
                        body[22] = 8'($urandom_range(0, 255));
                    while (body[22] == 8'd4 || body[22] == 8'd5);
                end
            end
            default:
            begin
            end
        endcase
        sum = '0;
        for (k = 0; k < 24; k++)
            sum = sum + body[k];
        if (kind == FK_CHECKSUM)
            sum = sum + 8'($urandom_range(1, 255));
        // A wrong target hides a checksum error as well.
        if (kind == FK_TARGET && $urandom_range(0, 1) != 0)
            sum = sum + 8'd1;
        body[24] = sum;
        if (kind == FK_NOISE)
        begin
            for (k = 0; k < 25; k++)
                body[k] = 8'($urandom_range(0, 255));
        end
        case (kind)
            FK_SHORT: n = $urandom_range(1, 24);
            FK_LONG:  n = $urandom_range(26, 40);
            FK_NOISE: n = $urandom_range(1, 40);
            default:  n = 25;
        endcase
        // Bytes past the normal length are filler that the checker skips.
        for (k = 0; k < n; k++)
        begin
            req.value = (k < 25) ? body[k] : 8'($urandom_range(0, 255));
            req.last = (k == n - 1);
            byte_q.push_back(req);
        end
        frames_queued++;
    endtask

    // Writes the target address while the checker is idle. Ready is looked
    // at mid-cycle, so the write lands on the following rising edge.
    task automatic write_target(logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        target_address <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
        model_target = value;
        target_writes++;
    endtask

    // Waits until every byte has gone in and every verdict has come out,
    // then lets the pipeline run dry before anything else happens.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] seen);
        if (seen !== want)
        begin
            if (fault_count < SHOW_LIMIT)
                $display("tb_top: %s mismatch at %0t: expected %h, got %h",
                         name, $time, want, seen);
            fault_count++;
        end
    endtask

    // Compares one accepted result request with the oldest verdict.
    task automatic check_verdict();
        rcfc_result_t want;
        if (verdict_q.size() == 0)
        begin
            if (fault_count < SHOW_LIMIT)
                $display("tb_top: result at %0t with no closing byte behind it", $time);
            fault_count++;
            return;
        end
        want = verdict_q.pop_front();
        verdicts_checked++;
        status_tally[int'(want.status)]++;
        compare_field("status_code", 32'(want.status), 32'(status_code));
        compare_field("rudder_bits", want.rudder, rudder_bits);
        compare_field("throttle_bits", want.throttle, throttle_bits);
        compare_field("aileron_bits", want.aileron, aileron_bits);
        compare_field("elevator_bits", want.elevator, elevator_bits);
        compare_field("arm_button", 32'(want.arm), 32'(arm_button));
        compare_field("flip_button", 32'(want.flip), 32'(flip_button));
        compare_field("ctrl_mode", 32'(want.control), 32'(ctrl_mode));
        compare_field("altitude_mode", 32'(want.altitude), 32'(altitude_mode));
        compare_field("attitude_reset", 32'(want.attitude), 32'(attitude_reset));
    endtask

    // Byte driver. A request that is stalled is held as it is; once taken,
    // it is folded into the prediction and the next one is offered after a
    // random gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            frame_byte <= '0;
            frame_end <= 1'b0;
            gap_left = 0;
            restart_frame();
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                track_frame_byte(frame_byte, frame_end);
                bytes_sent++;
            end
            if (in_valid && in_stall)
            begin
                // Hold the stalled request unchanged.
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (byte_q.size() != 0)
            begin
                frame_byte <= byte_q[0].value;
                frame_end <= byte_q[0].last;
                in_valid <= 1'b1;
                void'(byte_q.pop_front());
                gap_left = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor. Stall runs are started at random, short or long, and
    // a result request is checked on the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_verdict();
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (!quiet_phase && $urandom_range(0, 9) < 3)
            begin
                out_stall <= 1'b1;
                hold_left = pick_gap();
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Main sequence: reset once, then a run of phases, each under its own
    // target address. The two extreme addresses come first, random ones
    // after; every third phase runs without gaps or stalls.
    initial
    begin
        logic [23:0] phase_target;
        int          p;
        foreach (status_tally[i])
            status_tally[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_target = 24'hFFFFFF;
                1: phase_target = 24'h000000;
                default: phase_target = 24'($urandom());
            endcase
            write_target(phase_target);
            @(negedge clk);
            quiet_phase = (p % 3 == 1);
            if (p == 0)
            begin
                // A frame made of nothing but its closing byte, then a good
                // frame with the most extreme legal field values.
                byte_q.push_back('{value: 8'hFF, last: 1'b1});
                frames_queued++;
                queue_frame(FK_EXTREME);
            end
            while (byte_q.size() < PHASE_BYTES)
                queue_frame(pick_kind());
            wait_idle();
        end
        repeat (10) @(posedge clk);
        fault_count += verdict_q.size();
        $display("tb_top: %0d bytes in %0d frames under %0d target addresses, %0d verdicts",
                 bytes_sent, frames_queued, target_writes, verdicts_checked);
        $display("tb_top: ok %0d, length %0d, target %0d, checksum %0d, float %0d, mode %0d",
                 status_tally[STATUS_OK], status_tally[STATUS_BAD_LENGTH],
                 status_tally[STATUS_BAD_TARGET], status_tally[STATUS_CHECKSUM],
                 status_tally[STATUS_BAD_FLOAT], status_tally[STATUS_BAD_MODE]);
        if (fault_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, with the longest gaps and
    // stalls on every request.
    initial
    begin
        #1600000;
        $display("tb_top: timed out waiting for the checker");
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
